@@ src/brs_pkg.sv @@
// Shared constants, types and codes for the block range-sum table.
// No dependencies; imported by brs_engine and the top level.
package brs_pkg;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned BLOCK      = 32;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned LEN_W      = IDX_W + 1;
  localparam int unsigned OFS_W      = $clog2(BLOCK);
  localparam int unsigned NUM_BLOCKS = DEPTH / BLOCK;
  localparam int unsigned BLK_W      = $clog2(NUM_BLOCKS);

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_FIELDS_W = 2 * IDX_W + DATA_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((DATA_W + 7) / 8) * 8;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(DEPTH);

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic {
    STAT_OK    = 1'b0,
    STAT_RANGE = 1'b1
  } status_e;

  typedef enum logic {
    SRC_ELEM  = 1'b0,
    SRC_BLOCK = 1'b1
  } src_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_Q_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  last_index;
    logic [DATA_W-1:0] add_value;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] range_sum;
    status_e           status;
  } result_t;

endpackage

@@ src/brs_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module brs_ram #(
  parameter int unsigned DATA_W  = 64,
  parameter int unsigned N_WORDS = 1024,
  localparam int unsigned ADDR_W = $clog2(N_WORDS)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [N_WORDS];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/brs_engine.sv @@
// Command sequencer: clearing sweep, read-modify-write adds, range walk.
// Depends on brs_pkg and brs_ram (element store and block sums).
module brs_engine
  import brs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LEN_W-1:0] len_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cmd_t             in_cmd_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o
);

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [LEN_W-1:0]  ptr_q, ptr_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              pend_q, pend_d;
  src_e              tag_q, tag_d;
  status_e           status_q, status_d;
  logic [IDX_W-1:0]  clr_q, clr_d;

  logic              elem_we, elem_re;
  logic [IDX_W-1:0]  elem_waddr, elem_raddr;
  logic [DATA_W-1:0] elem_wdata, elem_rdata;
  logic              blk_we, blk_re;
  logic [BLK_W-1:0]  blk_waddr, blk_raddr;
  logic [DATA_W-1:0] blk_wdata, blk_rdata;

  logic [LEN_W-1:0]  len_eff;
  logic              first_bad, last_bad, in_bad;
  logic              ptr_in_range, blk_fits;
  logic [DATA_W-1:0] rd_data, acc_sum;

  brs_ram #(.DATA_W(DATA_W), .N_WORDS(DEPTH)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (elem_waddr),
    .wdata_i (elem_wdata),
    .re_i    (elem_re),
    .raddr_i (elem_raddr),
    .rdata_o (elem_rdata)
  );

  brs_ram #(.DATA_W(DATA_W), .N_WORDS(NUM_BLOCKS)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (blk_wdata),
    .re_i    (blk_re),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rdata)
  );

  // length check, saturated to the store size
  assign len_eff   = (len_i > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : len_i;
  assign first_bad = ({1'b0, in_cmd_i.first_index} >= len_eff);
  assign last_bad  = ({1'b0, in_cmd_i.last_index} >= len_eff);
  assign in_bad    = first_bad || ((in_cmd_i.cmd == CMD_QUERY) && last_bad);

  // walk: take a whole block when aligned and it fits inside the range
  assign ptr_in_range = (ptr_q <= {1'b0, cmd_q.last_index});
  assign blk_fits = (ptr_q[OFS_W-1:0] == '0) &&
                    (({1'b0, ptr_q} + (LEN_W+1)'(BLOCK - 1)) <=
                     (LEN_W+1)'(cmd_q.last_index));

  assign rd_data = (tag_q == SRC_BLOCK) ? blk_rdata : elem_rdata;
  assign acc_sum = acc_q + (pend_q ? rd_data : '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == IDX_W'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_bad)                          state_d = ST_DONE;
          else if (in_cmd_i.cmd == CMD_ADD)    state_d = ST_ADD_RD;
          else                                 state_d = ST_Q_RUN;
        end
      end
      ST_ADD_RD: state_d = ST_ADD_WR;
      ST_ADD_WR: state_d = ST_DONE;
      ST_Q_RUN: begin
        if (!ptr_in_range) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_d       = cmd_q;
    ptr_d       = ptr_q;
    acc_d       = acc_q;
    pend_d      = pend_q;
    tag_d       = tag_q;
    status_d    = status_q;
    clr_d       = clr_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    elem_we     = 1'b0;
    elem_waddr  = cmd_q.first_index;
    elem_wdata  = elem_rdata + cmd_q.add_value;
    elem_re     = 1'b0;
    elem_raddr  = cmd_q.first_index;
    blk_we      = 1'b0;
    blk_waddr   = cmd_q.first_index[IDX_W-1:OFS_W];
    blk_wdata   = blk_rdata + cmd_q.add_value;
    blk_re      = 1'b0;
    blk_raddr   = cmd_q.first_index[IDX_W-1:OFS_W];
    case (state_q)
      ST_CLEAR: begin
        elem_we    = 1'b1;
        elem_waddr = clr_q;
        elem_wdata = '0;
        blk_we     = 1'b1;
        blk_waddr  = clr_q[BLK_W-1:0];
        blk_wdata  = '0;
        clr_d      = clr_q + 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d    = in_cmd_i;
          ptr_d    = {1'b0, in_cmd_i.first_index};
          acc_d    = '0;
          pend_d   = 1'b0;
          status_d = in_bad ? STAT_RANGE : STAT_OK;
        end
      end
      ST_ADD_RD: begin
        elem_re = 1'b1;
        blk_re  = 1'b1;
      end
      ST_ADD_WR: begin
        elem_we = 1'b1;
        blk_we  = 1'b1;
      end
      ST_Q_RUN: begin
        acc_d  = acc_sum;
        pend_d = 1'b0;
        if (ptr_in_range) begin
          pend_d = 1'b1;
          if (blk_fits) begin
            blk_re    = 1'b1;
            blk_raddr = ptr_q[IDX_W-1:OFS_W];
            tag_d     = SRC_BLOCK;
            ptr_d     = ptr_q + LEN_W'(BLOCK);
          end else begin
            elem_re    = 1'b1;
            elem_raddr = ptr_q[IDX_W-1:0];
            tag_d      = SRC_ELEM;
            ptr_d      = ptr_q + 1'b1;
          end
        end
      end
      ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      pend_q  <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    ptr_q    <= ptr_d;
    acc_q    <= acc_d;
    tag_q    <= tag_d;
    status_q <= status_d;
  end

  assign res_o.range_sum = acc_q;
  assign res_o.status    = status_q;

  // a pending accumulate always follows a memory read issued the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(elem_re || blk_re))
    else $error("accumulate without a preceding read");

  // a range walk never writes either store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_RUN) |-> !(elem_we || blk_we))
    else $error("store written during a range walk");

  // flagged commands carry a zero sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status == STAT_RANGE)) |-> (res_o.range_sum == '0))
    else $error("flagged result with nonzero sum");

  // an accepted beat closes the input until its result is handed off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat accepted while busy");

endmodule

@@ src/block_range_sum_table_top.sv @@
// Top level of the block range-sum table: configuration register,
// stream unpacking and output register around brs_engine.
// Depends on brs_pkg, brs_engine and brs_ram.
//
// Usage
// - Slave stream carries one command per beat: tuser[0] is the command
//   (0 add, 1 range query); tdata holds first_index, last_index, add_value.
// - Master stream returns exactly one result beat per command: tdata is the
//   wrapped 64-bit sum (zero for adds and flagged commands), tuser[0] is the
//   status (1 when first_index or a query's last_index is >= length_in_use).
// - cfg_wr_en_i writes length_in_use; values above 1024 act as 1024.
//   Write it only while no command is in flight.
// Operation
// - After reset both stores are swept to zero, one entry per cycle, while
//   s_axis_tready_o stays low.
// - One command at a time. A flagged command goes from accept straight to
//   hand-off; an add steps through accept, read, write back, hand-off. A query
//   makes one memory read per step of the range walk: one per edge element and
//   one per whole aligned block, at most 92 reads for a 1024-entry store.
//   Each store has a single read port, so the walk issues its reads in turn.
// - A finished result sits in the output register; the next command is
//   taken while it waits. If the receiver stalls further, the engine holds
//   its next result and stops accepting until the register frees up.
module block_range_sum_table_top
  import brs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wr_en_i,
  input  logic [LEN_W-1:0]       cfg_wr_data_i,   // length_in_use
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [9:0] first_index, [19:10] last_index, [83:20] add_value, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic [0:0]             s_axis_tuser_i,  // [0] cmd
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // [63:0] range_sum
  output logic [0:0]             m_axis_tuser_o   // [0] status
);

  logic [LEN_W-1:0] len_q;
  cmd_t             in_cmd;
  logic             res_valid, res_ready;
  result_t          res;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_wr_en_i) begin
      len_q <= cfg_wr_data_i;
    end
  end

  // unpack the slave beat
  assign in_cmd.cmd         = cmd_e'(s_axis_tuser_i[0]);
  assign in_cmd.first_index = s_axis_tdata_i[IDX_W-1:0];
  assign in_cmd.last_index  = s_axis_tdata_i[2*IDX_W-1:IDX_W];
  assign in_cmd.add_value   = s_axis_tdata_i[2*IDX_W+DATA_W-1:2*IDX_W];

  brs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_i       (len_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (in_cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = OUT_TDATA_W'(out_q.range_sum);
  assign m_axis_tuser_o[0] = out_q.status;

endmodule
